@@ hw/rtl/i2ctm_pkg.sv @@
package i2ctm_pkg;

  localparam int QUARTER_W  = 10;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [QUARTER_W-1:0] QUARTER_RESET = 10'd50;

  // register index, taken from paddr[2]
  localparam logic REG_QUARTER_TICKS = 1'b0;

  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_CONVERT = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [7:0] ADDR_WRITE_BASE  = 8'h90;
  localparam logic [7:0] ADDR_READ_BASE   = 8'h91;
  localparam logic [7:0] CMD_BYTE_CONVERT = 8'hEE;
  localparam logic [7:0] CMD_BYTE_READ    = 8'hAA;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] sensor_index;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic       success;
    logic [7:0] temp_high;
    logic [7:0] temp_low;
  } result_t;

endpackage

@@ hw/rtl/i2ctm_if.sv @@
interface i2ctm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [2:0] sensor_index;
  logic       sda_in;

  modport source(output valid, command, sensor_index, sda_in, input ready);
  modport sink(input valid, command, sensor_index, sda_in, output ready);
endinterface

interface i2ctm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_pull_low;
  logic       busy_res;
  logic       done_res;
  logic       success;
  logic [7:0] temp_high;
  logic [7:0] temp_low;

  modport source(output valid, scl_out, sda_pull_low, busy_res, done_res, success,
                 temp_high, temp_low, input ready);
  modport sink(input valid, scl_out, sda_pull_low, busy_res, done_res, success,
               temp_high, temp_low, output ready);
endinterface

@@ hw/rtl/i2ctm_cfg_regs.sv @@
module i2ctm_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2ctm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [i2ctm_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [i2ctm_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  output logic [i2ctm_pkg::QUARTER_W-1:0]     quarter_ticks
);

  logic [i2ctm_pkg::QUARTER_W-1:0] quarter_r;
  logic                            wr_en;
  logic                            sel_quarter;

  assign pready      = 1'b1;
  assign sel_quarter = (paddr[2] == i2ctm_pkg::REG_QUARTER_TICKS);
  assign wr_en       = psel && penable && pwrite && pready && sel_quarter;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quarter_r <= i2ctm_pkg::QUARTER_RESET;
    end else if (wr_en) begin
      quarter_r <= pwdata[i2ctm_pkg::QUARTER_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_quarter) begin
      prdata[i2ctm_pkg::QUARTER_W-1:0] = quarter_r;
    end
  end

  assign quarter_ticks = quarter_r;

endmodule

@@ hw/rtl/i2ctm_core.sv @@
module i2ctm_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  i2ctm_pkg::in_item_t             item,
  input  logic [i2ctm_pkg::QUARTER_W-1:0] quarter_ticks,
  output i2ctm_pkg::result_t              res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_S_HI, PH_S_LO, PH_ADDR, PH_CMD, PH_RS_HI, PH_RS_LO, PH_RADDR,
    PH_RX1, PH_MACK, PH_RX2, PH_STOP_LO, PH_STOP_HI, PH_TAIL
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic                            op_read_r, op_read_nxt;
  logic [i2ctm_pkg::QUARTER_W-1:0] tick_r, tick_nxt;
  logic [1:0]                      qstep_r, qstep_nxt;
  logic [3:0]                      bit_cnt_r, bit_cnt_nxt;
  logic [7:0]                      shift_r, shift_nxt;
  logic [2:0]                      addr_r, addr_nxt;
  logic [7:0]                      hi_r, hi_nxt;
  logic [7:0]                      lo_r, lo_nxt;

  logic [i2ctm_pkg::QUARTER_W-1:0] q_eff;
  logic                            quarter_end;
  logic                            cur_send, cur_bit;
  logic                            nxt_send, nxt_bit;
  logic                            done;

  assign q_eff       = (quarter_ticks == '0) ? {{(i2ctm_pkg::QUARTER_W-1){1'b0}}, 1'b1}
                                             : quarter_ticks;
  assign quarter_end = !(({1'b0, tick_r} + {{i2ctm_pkg::QUARTER_W{1'b0}}, 1'b1})
                         < {1'b0, q_eff});

  assign cur_send = (phase_r == PH_ADDR) || (phase_r == PH_CMD) || (phase_r == PH_RADDR);
  assign cur_bit  = cur_send || (phase_r == PH_RX1) || (phase_r == PH_MACK) ||
                    (phase_r == PH_RX2);
  assign nxt_send = (phase_nxt == PH_ADDR) || (phase_nxt == PH_CMD) ||
                    (phase_nxt == PH_RADDR);
  assign nxt_bit  = nxt_send || (phase_nxt == PH_RX1) || (phase_nxt == PH_MACK) ||
                    (phase_nxt == PH_RX2);

  always_comb begin
    phase_nxt   = phase_r;
    op_read_nxt = op_read_r;
    tick_nxt    = tick_r;
    qstep_nxt   = qstep_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    addr_nxt    = addr_r;
    hi_nxt      = hi_r;
    lo_nxt      = lo_r;
    done        = 1'b0;

    if (step) begin
      if (phase_r == PH_IDLE) begin
        if (item.command == i2ctm_pkg::CMD_CONVERT || item.command == i2ctm_pkg::CMD_READ) begin
          op_read_nxt = (item.command == i2ctm_pkg::CMD_READ);
          addr_nxt    = item.sensor_index;
          phase_nxt   = PH_S_HI;
          tick_nxt    = '0;
          qstep_nxt   = 2'd0;
          bit_cnt_nxt = 4'd0;
          shift_nxt   = 8'h00;
          hi_nxt      = 8'h00;
          lo_nxt      = 8'h00;
        end
      end else if (!quarter_end) begin
        tick_nxt = tick_r + {{(i2ctm_pkg::QUARTER_W-1){1'b0}}, 1'b1};
      end else begin
        tick_nxt = '0;
        if (cur_bit) begin
          // sample SDA at the end of the first SCL-high quarter
          if (qstep_r == 2'd1) begin
            if (cur_send) begin
              if (bit_cnt_r >= 4'd8) begin
                shift_nxt = {7'b0, item.sda_in};
              end
            end else if (phase_r != PH_MACK) begin
              shift_nxt = {shift_r[6:0], item.sda_in};
            end
          end
          if (qstep_r != 2'd3) begin
            qstep_nxt = qstep_r + 2'd1;
          end else begin
            qstep_nxt = 2'd0;
            if (cur_send) begin
              if (bit_cnt_r < 4'd8) begin
                shift_nxt   = {shift_nxt[6:0], 1'b0};
                bit_cnt_nxt = bit_cnt_r + 4'd1;
              end else if (shift_nxt[0]) begin
                // no ACK from the slave: abort with failure
                phase_nxt   = PH_STOP_LO;
                bit_cnt_nxt = 4'd0;
              end else begin
                bit_cnt_nxt = 4'd0;
                case (phase_r)
                  PH_ADDR: begin
                    phase_nxt = PH_CMD;
                    shift_nxt = op_read_r ? i2ctm_pkg::CMD_BYTE_READ
                                          : i2ctm_pkg::CMD_BYTE_CONVERT;
                  end
                  PH_CMD: begin
                    if (op_read_r) begin
                      phase_nxt = PH_RS_HI;
                    end else begin
                      phase_nxt   = PH_STOP_LO;
                      bit_cnt_nxt = 4'd1;
                    end
                  end
                  default: begin
                    phase_nxt = PH_RX1;
                    shift_nxt = 8'h00;
                  end
                endcase
              end
            end else if (phase_r == PH_MACK) begin
              phase_nxt   = PH_RX2;
              shift_nxt   = 8'h00;
              bit_cnt_nxt = 4'd0;
            end else begin
              bit_cnt_nxt = bit_cnt_r + 4'd1;
              if (bit_cnt_nxt >= 4'd8) begin
                if (phase_r == PH_RX1) begin
                  hi_nxt      = shift_nxt;
                  bit_cnt_nxt = 4'd0;
                  phase_nxt   = PH_MACK;
                end else begin
                  lo_nxt      = shift_nxt;
                  phase_nxt   = PH_STOP_LO;
                  bit_cnt_nxt = 4'd1;
                end
              end
            end
          end
        end else if (phase_r == PH_TAIL) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end else if (qstep_r == 2'd0) begin
          qstep_nxt = 2'd1;
        end else begin
          qstep_nxt = 2'd0;
          case (phase_r)
            PH_S_HI:  phase_nxt = PH_S_LO;
            PH_S_LO: begin
              phase_nxt   = PH_ADDR;
              bit_cnt_nxt = 4'd0;
              shift_nxt   = i2ctm_pkg::ADDR_WRITE_BASE + {4'b0, addr_r, 1'b0};
            end
            PH_RS_HI: phase_nxt = PH_RS_LO;
            PH_RS_LO: begin
              phase_nxt   = PH_RADDR;
              bit_cnt_nxt = 4'd0;
              shift_nxt   = i2ctm_pkg::ADDR_READ_BASE + {4'b0, addr_r, 1'b0};
            end
            PH_STOP_LO: phase_nxt = PH_STOP_HI;
            PH_STOP_HI: phase_nxt = PH_TAIL;
            default:    phase_nxt = PH_IDLE;
          endcase
        end
        if (done) begin
          qstep_nxt = 2'd0;
        end
      end
    end
  end

  always_comb begin
    res              = '0;
    res.scl_out      = 1'b1;
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.done_res     = done;
    if (done) begin
      res.success = bit_cnt_nxt[0];
      if (bit_cnt_nxt[0] && op_read_nxt) begin
        res.temp_high = hi_nxt;
        res.temp_low  = lo_nxt;
      end
    end
    case (phase_nxt)
      PH_S_LO, PH_RS_LO: res.sda_pull_low = 1'b1;
      PH_STOP_LO: begin
        res.scl_out      = 1'b0;
        res.sda_pull_low = 1'b1;
      end
      default: begin
        if (nxt_bit) begin
          res.scl_out = (qstep_nxt == 2'd1) || (qstep_nxt == 2'd2);
          if (phase_nxt == PH_MACK) begin
            res.sda_pull_low = 1'b1;
          end else if (nxt_send && bit_cnt_nxt < 4'd8) begin
            res.sda_pull_low = !shift_nxt[7];
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      op_read_r <= 1'b0;
      tick_r    <= '0;
      qstep_r   <= 2'd0;
      bit_cnt_r <= 4'd0;
      shift_r   <= 8'h00;
      addr_r    <= 3'd0;
      hi_r      <= 8'h00;
      lo_r      <= 8'h00;
    end else begin
      phase_r   <= phase_nxt;
      op_read_r <= op_read_nxt;
      tick_r    <= tick_nxt;
      qstep_r   <= qstep_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      addr_r    <= addr_nxt;
      hi_r      <= hi_nxt;
      lo_r      <= lo_nxt;
    end
  end

  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= 4'd8)
    else $error("bit counter past ninth bit");

  a_done_lines_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !res.busy_res && res.scl_out && !res.sda_pull_low)
    else $error("done without idle lines");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(tick_r) && $stable(shift_r))
    else $error("state moved without an item");

  a_done_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> phase_r == PH_TAIL && qstep_nxt == 2'd0)
    else $error("done outside tail wait");

endmodule

@@ hw/rtl/i2c_temp_sensor_master_unit.sv @@
// Channel  Dir  Handshake      Payload
// in_chan  in   valid/ready    command, sensor_index, sda_in (one timer tick)
// out_chan out  valid/ready    scl_out, sda_pull_low, busy_res, done_res, success,
//                              temp_high, temp_low (one result per tick)
// cfg_*    in   APB, pready=1  quarter_ticks at byte address 0
//
// One item per clock sustained while the output is not stalled; each item passes from
// acceptance to result through the input register, then the controller step into the output register.
// Reset (rst_n low, synchronous) empties both registers, idles the controller
// and sets quarter_ticks to 50.
// A stalled output holds its result; the input register still takes one item
// and then holds it until the output frees.
module i2c_temp_sensor_master_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  i2ctm_in_if.sink                         in_chan,
  i2ctm_out_if.source                      out_chan,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [i2ctm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [i2ctm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [i2ctm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                             cfg_pready
);

  logic                            in_valid_r;
  i2ctm_pkg::in_item_t             in_item_r;
  logic                            out_valid_r;
  i2ctm_pkg::result_t              out_res_r;
  i2ctm_pkg::result_t              core_res;
  logic                            advance;
  logic [i2ctm_pkg::QUARTER_W-1:0] quarter_ticks;

  i2ctm_cfg_regs u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (cfg_prdata),
    .pready        (cfg_pready),
    .quarter_ticks (quarter_ticks)
  );

  // advance the held item when the output register is free or draining
  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;

  i2ctm_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .item          (in_item_r),
    .quarter_ticks (quarter_ticks),
    .res           (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_item_r.command      <= in_chan.command;
      in_item_r.sensor_index <= in_chan.sensor_index;
      in_item_r.sda_in       <= in_chan.sda_in;
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.scl_out      = out_res_r.scl_out;
  assign out_chan.sda_pull_low = out_res_r.sda_pull_low;
  assign out_chan.busy_res     = out_res_r.busy_res;
  assign out_chan.done_res     = out_res_r.done_res;
  assign out_chan.success      = out_res_r.success;
  assign out_chan.temp_high    = out_res_r.temp_high;
  assign out_chan.temp_low     = out_res_r.temp_low;

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("stepped item lost before output");

  a_held_item_waits: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_item_r))
    else $error("held item dropped while output stalled");

endmodule
